// ===== rtl/tbv_pkg.sv =====
// Shared types, constants and saturation helpers for the two-body Verlet orbit stepper.
// Used by every module of the block; depends on nothing.
package tbv_pkg;

  // Field widths.
  localparam int POS_W  = 48;
  localparam int VEL_W  = 40;
  localparam int ACC_W  = 48;
  localparam int DT_W   = 32;
  localparam int RAW_W  = 4;
  localparam int STAT_W = 2;

  // Default table size.
  localparam int SATELLITES_DEF = 16;

  // Stream widths (fields packed from bit 0, padded to whole bytes).
  localparam int S_TDATA_W = 184;
  localparam int M_TDATA_W = 152;

  // Reset value of dt: one second in Q16.16.
  localparam logic [DT_W-1:0] DT_RESET = 32'd65536;

  // GM of the central body in m^3/s^2.
  localparam logic [48:0] GM_VALUE = 49'd398600000000000;

  // Acceleration magnitude limit, 2^48.
  localparam logic [48:0] AM_LIM = {1'b1, 48'd0};

  // Width of the shared serial arithmetic unit and its step counter.
  localparam int AW    = 128;
  localparam int CNT_W = 8;

  // Front-to-back queue.
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = 1;

  // Item commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Arithmetic unit operations.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

  // One queued input item.
  typedef struct packed {
    logic             cmd;
    logic [RAW_W-1:0] idx;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [VEL_W-1:0] vx;
    logic [VEL_W-1:0] vy;
  } item_t;

  // Request to the serial arithmetic unit.
  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic [AW-1:0]    a;
    logic [AW-1:0]    b;
    logic [CNT_W-1:0] nbits;
  } arith_req_t;

  // Response of the serial arithmetic unit.
  typedef struct packed {
    logic          busy;
    logic          done;
    logic [AW-1:0] res;
  } arith_rsp_t;

  // Magnitudes of two's complement values.
  function automatic logic [POS_W-1:0] mag48(input logic [POS_W-1:0] v);
    return v[POS_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [VEL_W-1:0] mag40(input logic [VEL_W-1:0] v);
    return v[VEL_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Overflow tests and clamps of a 58-bit signed sum.
  function automatic logic ovf40(input logic [57:0] v);
    return !((&v[57:39]) || !(|v[57:39]));
  endfunction

  function automatic logic [VEL_W-1:0] sat40(input logic [57:0] v);
    if (ovf40(v)) return v[57] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    return v[VEL_W-1:0];
  endfunction

  function automatic logic ovf48(input logic [57:0] v);
    return !((&v[57:47]) || !(|v[57:47]));
  endfunction

  function automatic logic [POS_W-1:0] sat48(input logic [57:0] v);
    if (ovf48(v)) return v[57] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== rtl/tbv_front.sv =====
// Front end: accepts input beats, unpacks and classifies them into a short queue.
// Depends on tbv_pkg.
module tbv_front
  import tbv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 pop,
  output logic                 q_valid,
  output item_t                head
);

  item_t            q_mem [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QP_W:0]    count;
  item_t            in_item;
  logic             push;

  // Unpack one beat; tuser carries the command.
  always_comb begin
    in_item.cmd = s_tuser;
    in_item.idx = s_tdata[3:0];
    in_item.px  = s_tdata[51:4];
    in_item.py  = s_tdata[99:52];
    in_item.vx  = s_tdata[139:100];
    in_item.vy  = s_tdata[179:140];
  end

  assign s_tready = (count != (QP_W+1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign head     = q_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // The back end never takes an item from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("queue popped while empty");

endmodule

// ===== rtl/tbv_arith.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide, digit square root.
// Depends on tbv_pkg.
module tbv_arith
  import tbv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic [1:0]       op;
  logic [AW-1:0]    x_a;
  logic [AW-1:0]    x_b;
  logic [AW-1:0]    x_q;
  logic [AW:0]      x_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [AW-1:0]    sum_mul;
  logic [AW:0]      r_div;
  logic [AW:0]      r_sq;
  logic [AW:0]      trial;
  logic [AW:0]      dsub;
  logic [AW:0]      ssub;

  // One step of each operation.
  always_comb begin
    sum_mul = x_q + x_a;
    r_div   = {x_r[AW-1:0], x_a[AW-1]};
    r_sq    = {x_r[AW-2:0], x_a[AW-1:AW-2]};
    trial   = {x_q[AW-2:0], 2'b01};
    dsub    = r_div - {1'b0, x_b};
    ssub    = r_sq - trial;
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      x_a <= req.a;
      x_b <= req.b;
      x_q <= '0;
      x_r <= '0;
      cnt <= req.nbits;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      unique case (op)
        OP_MUL: begin
          if (x_b[0]) x_q <= sum_mul;
          x_a <= x_a << 1;
          x_b <= x_b >> 1;
        end
        OP_DIV: begin
          x_a <= x_a << 1;
          if (r_div >= {1'b0, x_b}) begin
            x_r <= dsub;
            x_q <= {x_q[AW-2:0], 1'b1};
          end else begin
            x_r <= r_div;
            x_q <= {x_q[AW-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          x_a <= x_a << 2;
          if (r_sq >= trial) begin
            x_r <= ssub;
            x_q <= {x_q[AW-2:0], 1'b1};
          end else begin
            x_r <= r_sq;
            x_q <= {x_q[AW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  // Busy and done control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.res  = x_q;

endmodule

// ===== rtl/tbv_back.sv =====
// Back end: sequencer that runs load and step items over the satellite tables.
// Depends on tbv_pkg; drives the shared tbv_arith unit.
module tbv_back
  import tbv_pkg::*;
#(
  parameter int SATELLITES = SATELLITES_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic [DT_W-1:0]   time_step,
  input  logic              q_valid,
  input  item_t             head,
  output logic              pop,
  output arith_req_t        arith_req,
  input  arith_rsp_t        arith_rsp,
  input  logic              out_ready,
  output logic              out_load,
  output logic [RAW_W-1:0]  out_idx,
  output logic [POS_W-1:0]  out_px,
  output logic [POS_W-1:0]  out_py,
  output logic [POS_W-1:0]  out_rad,
  output logic [STAT_W-1:0] out_stat
);

  localparam int IDX_W = (SATELLITES > 1) ? $clog2(SATELLITES) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_KICK1 = 4'd2;
  localparam logic [3:0] ST_DRIFT = 4'd3;
  localparam logic [3:0] ST_ZCHK  = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_ROOT  = 4'd6;
  localparam logic [3:0] ST_GDIV  = 4'd7;
  localparam logic [3:0] ST_UDIV  = 4'd8;
  localparam logic [3:0] ST_GMUL  = 4'd9;
  localparam logic [3:0] ST_KICK2 = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  // Satellite tables.
  logic [POS_W-1:0] mem_px [SATELLITES];
  logic [POS_W-1:0] mem_py [SATELLITES];
  logic [VEL_W-1:0] mem_vx [SATELLITES];
  logic [VEL_W-1:0] mem_vy [SATELLITES];
  logic [ACC_W-1:0] mem_ax [SATELLITES];
  logic [ACC_W-1:0] mem_ay [SATELLITES];

  // Working state of the current item.
  logic [3:0]       state;
  logic             pend;
  logic             axis;
  logic             cmd;
  logic [RAW_W-1:0] raw_idx;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_next;
  logic [POS_W-1:0] pos [2];
  logic [VEL_W-1:0] vel [2];
  logic [ACC_W-1:0] acc [2];
  logic [96:0]      r2;
  logic [48:0]      rad;
  logic [79:0]      g;
  logic             gbig;
  logic             sat;
  logic             zero;

  // Quotient of the last axis divide, kept for the following multiply.
  logic [32:0]      u;

  logic             is_op;
  logic [POS_W-1:0] mag_pos;
  logic [VEL_W-1:0] mag_vel;
  logic [ACC_W-1:0] mag_acc;
  logic [57:0]      s_kick;
  logic [57:0]      s_drift;
  logic [57:0]      kick_sum;
  logic [57:0]      drift_sum;
  logic [48:0]      am;
  logic [57:0]      am_ext;
  logic [57:0]      acc_sum;
  logic [79:0]      p2;

  // Entry number: the raw index folded into the table size.
  always_comb begin
    k_next = '0;
    for (int i = 0; i < 16; i++) begin
      if (head.idx == RAW_W'(i)) k_next = IDX_W'(i % SATELLITES);
    end
  end

  // Operand magnitudes of the current axis.
  assign mag_pos = mag48(pos[axis]);
  assign mag_vel = mag40(vel[axis]);
  assign mag_acc = mag48(acc[axis]);

  // Kick, drift and acceleration sums from the unit's result.
  always_comb begin
    s_kick    = {11'd0, arith_rsp.res[79:33]};
    s_drift   = {2'd0, arith_rsp.res[71:16]};
    kick_sum  = {{18{vel[axis][VEL_W-1]}}, vel[axis]}
              + (acc[axis][ACC_W-1] ? (~s_kick + 1'b1) : s_kick);
    drift_sum = {{10{pos[axis][POS_W-1]}}, pos[axis]}
              + (vel[axis][VEL_W-1] ? (~s_drift + 1'b1) : s_drift);
    p2        = arith_rsp.res[111:32];
    if (state == ST_UDIV) begin
      am = (|arith_rsp.res[32:0]) ? AM_LIM : '0;
    end else if ((|p2[79:49]) || (p2[48] && (|p2[47:0]))) begin
      am = AM_LIM;
    end else begin
      am = p2[48:0];
    end
    am_ext  = {9'd0, am};
    acc_sum = pos[axis][POS_W-1] ? am_ext : (~am_ext + 1'b1);
  end

  // Request to the arithmetic unit for the current state.
  always_comb begin
    arith_req = '0;
    is_op     = 1'b0;
    case (state) inside
      ST_KICK1, ST_KICK2: begin
        is_op           = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.a     = AW'(mag_acc);
        arith_req.b     = AW'(time_step);
        arith_req.nbits = CNT_W'(DT_W);
      end
      ST_DRIFT: begin
        is_op           = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.a     = AW'(mag_vel);
        arith_req.b     = AW'(time_step);
        arith_req.nbits = CNT_W'(DT_W);
      end
      ST_SQ: begin
        is_op           = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.a     = AW'(mag_pos);
        arith_req.b     = AW'(mag_pos);
        arith_req.nbits = CNT_W'(POS_W);
      end
      ST_ROOT: begin
        is_op           = 1'b1;
        arith_req.op    = OP_SQRT;
        arith_req.a     = AW'(r2) << 30;
        arith_req.nbits = CNT_W'(49);
      end
      ST_GDIV: begin
        is_op           = 1'b1;
        arith_req.op    = OP_DIV;
        arith_req.a     = AW'(GM_VALUE) << 79;
        arith_req.b     = AW'(r2);
        arith_req.nbits = CNT_W'(113);
      end
      ST_UDIV: begin
        is_op           = 1'b1;
        arith_req.op    = OP_DIV;
        arith_req.a     = AW'(mag_pos) << 80;
        arith_req.b     = AW'(rad);
        arith_req.nbits = CNT_W'(80);
      end
      ST_GMUL: begin
        is_op           = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.a     = AW'(g);
        arith_req.b     = AW'(u);
        arith_req.nbits = CNT_W'(33);
      end
      default: ;
    endcase
    arith_req.start = is_op && !pend;
  end

  assign pop      = (state == ST_IDLE) && q_valid;
  assign out_load = (state == ST_DONE) && out_ready;
  assign out_idx  = raw_idx;
  assign out_px   = pos[0];
  assign out_py   = pos[1];
  assign out_rad  = rad[POS_W-1:0];
  assign out_stat = sat ? STAT_SAT : (zero ? STAT_ZERO : STAT_OK);

  // Table write-back at the end of an item.
  always_ff @(posedge clk) begin
    if (out_load) begin
      mem_px[k] <= pos[0];
      mem_py[k] <= pos[1];
      mem_vx[k] <= vel[0];
      mem_vy[k] <= vel[1];
      mem_ax[k] <= acc[0];
      mem_ay[k] <= acc[1];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      axis  <= 1'b0;
    end else begin
      if (arith_req.start) pend <= 1'b1;
      if (arith_rsp.done) pend <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd     <= head.cmd;
            raw_idx <= head.idx;
            k       <= k_next;
            sat     <= 1'b0;
            zero    <= 1'b0;
            axis    <= 1'b0;
            if (head.cmd == CMD_LOAD) begin
              pos[0] <= head.px;
              pos[1] <= head.py;
              vel[0] <= head.vx;
              vel[1] <= head.vy;
              state  <= ST_ZCHK;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          pos[0] <= mem_px[k];
          pos[1] <= mem_py[k];
          vel[0] <= mem_vx[k];
          vel[1] <= mem_vy[k];
          acc[0] <= mem_ax[k];
          acc[1] <= mem_ay[k];
          state  <= ST_KICK1;
        end
        ST_KICK1, ST_KICK2: begin
          if (arith_rsp.done) begin
            vel[axis] <= sat40(kick_sum);
            if (ovf40(kick_sum)) sat <= 1'b1;
            axis <= !axis;
            if (axis) state <= (state == ST_KICK1) ? ST_DRIFT : ST_DONE;
          end
        end
        ST_DRIFT: begin
          if (arith_rsp.done) begin
            pos[axis] <= sat48(drift_sum);
            if (ovf48(drift_sum)) sat <= 1'b1;
            axis <= !axis;
            if (axis) state <= ST_ZCHK;
          end
        end
        ST_ZCHK: begin
          axis <= 1'b0;
          r2   <= '0;
          if (pos[0] == '0 && pos[1] == '0) begin
            acc[0] <= '0;
            acc[1] <= '0;
            rad    <= '0;
            zero   <= 1'b1;
            state  <= (cmd == CMD_STEP) ? ST_KICK2 : ST_DONE;
          end else begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (arith_rsp.done) begin
            r2   <= r2 + arith_rsp.res[96:0];
            axis <= !axis;
            if (axis) state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (arith_rsp.done) begin
            rad   <= arith_rsp.res[48:0];
            state <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          if (arith_rsp.done) begin
            g     <= arith_rsp.res[79:0];
            gbig  <= |arith_rsp.res[112:80];
            state <= ST_UDIV;
          end
        end
        ST_UDIV: begin
          if (arith_rsp.done) begin
            u <= arith_rsp.res[32:0];
            if (gbig) begin
              acc[axis] <= sat48(acc_sum);
              if (ovf48(acc_sum)) sat <= 1'b1;
              axis <= !axis;
              if (axis) state <= (cmd == CMD_STEP) ? ST_KICK2 : ST_DONE;
            end else begin
              state <= ST_GMUL;
            end
          end
        end
        ST_GMUL: begin
          if (arith_rsp.done) begin
            acc[axis] <= sat48(acc_sum);
            if (ovf48(acc_sum)) sat <= 1'b1;
            axis <= !axis;
            if (axis) state <= (cmd == CMD_STEP) ? ST_KICK2 : ST_DONE;
            else state <= ST_UDIV;
          end
        end
        ST_DONE: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A new operation is only started on an idle unit.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    arith_req.start |-> !arith_rsp.busy)
    else $error("arithmetic unit started while busy");

  // Every completion answers an operation that this sequencer issued.
  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    arith_rsp.done |-> pend)
    else $error("arithmetic completion without a pending request");

endmodule

// ===== rtl/two_body_verlet_orbit_step.sv =====
// Each input beat either loads a satellite's position and velocity (and computes its initial
// acceleration -GM*p/r^3) or advances it one velocity Verlet step of the configured dt; each
// beat returns one result with the position, radius and a status. Items are worked one at a
// time by a sequencer that drives a single shared bit-serial multiply/divide/square-root unit,
// which sets the rate. A step runs more operations than a load, and either runs fewer when
// gravity is so strong that the per-axis multiply is skipped; at zero radius a load runs no
// operation and a step only its kicks and drift, and a stalled output holds the item in
// progress. A two-entry queue in front and an output register behind let the input and
// output sides stall independently. Depends on tbv_pkg.
module two_body_verlet_orbit_step
  import tbv_pkg::*;
#(
  parameter int SATELLITES = SATELLITES_DEF
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [DT_W-1:0]      cfg_wdata,     // time_step, unsigned Q16.16 s
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sat_index[3:0], load_pos_x[51:4], load_pos_y[99:52], load_vel_x[139:100],
  // load_vel_y[179:140], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,  // command[0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_index[3:0], out_pos_x[51:4], out_pos_y[99:52], out_radius[147:100], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [STAT_W-1:0]    m_axis_tuser   // status[1:0]
);

  logic [DT_W-1:0]   time_step;
  logic              q_valid;
  logic              pop;
  item_t             head;
  arith_req_t        arith_req;
  arith_rsp_t        arith_rsp;
  logic              out_ready;
  logic              out_load;
  logic [RAW_W-1:0]  out_idx;
  logic [POS_W-1:0]  out_px;
  logic [POS_W-1:0]  out_py;
  logic [POS_W-1:0]  out_rad;
  logic [STAT_W-1:0] out_stat;

  // Step size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= DT_RESET;
    end else if (cfg_we) begin
      time_step <= cfg_wdata;
    end
  end

  tbv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser[0]),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  tbv_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  tbv_back #(
    .SATELLITES (SATELLITES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .time_step (time_step),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .arith_req (arith_req),
    .arith_rsp (arith_rsp),
    .out_ready (out_ready),
    .out_load  (out_load),
    .out_idx   (out_idx),
    .out_px    (out_px),
    .out_py    (out_py),
    .out_rad   (out_rad),
    .out_stat  (out_stat)
  );

  // Output register: holds a result beat until the sink takes it.
  assign out_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'd0, out_rad, out_py, out_px, out_idx};
      m_axis_tuser <= out_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // A zero-radius result reports a zero radius and a zero position.
  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == STAT_ZERO) |->
      (m_axis_tdata[147:100] == '0 && m_axis_tdata[99:4] == '0))
    else $error("zero-radius status with nonzero position or radius");

endmodule
